FILE: hdl/rkad_pkg.sv
// Shared constants and types for the repeating-key additive descrambler.
package rkad_pkg;

   localparam int KEY_DEPTH_DEF = 256;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 9;
   localparam int SUM_W    = 32;

   localparam logic [LEN_W-1:0] LEN_MAX = 9'd256;

   typedef enum logic [0:0] {
      OP_KEY_WRITE = 1'b0,
      OP_DATA      = 1'b1
   } opcode_type;

endpackage

FILE: hdl/rkad_key_store.sv
// Key byte memory: one write port, one read port with registered read data.
module rkad_key_store #(
   parameter int KEY_DEPTH = rkad_pkg::KEY_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(KEY_DEPTH)-1:0]           wr_addr,
   input  logic [rkad_pkg::BYTE_W-1:0]            wr_data,
   input  logic                                   rd_en,
   input  logic [$clog2(KEY_DEPTH)-1:0]           rd_addr,
   output logic [rkad_pkg::BYTE_W-1:0]            rd_data
);

   logic [rkad_pkg::BYTE_W-1:0] mem [KEY_DEPTH];
   logic [rkad_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/repeating_key_additive_descrambler.sv
// Top level of the repeating-key additive descrambler.
// Data words pass the stage-one and output registers. Throughput: one word
// per cycle unless stalled, key writes and data words alike; the key store
// has one write and one read port and each word uses at most one. Reset
// clears key position, running sum and pipeline valids and sets the key
// length to 256; the key store is not cleared and must be loaded first.
module repeating_key_additive_descrambler #(
   parameter int KEY_DEPTH = rkad_pkg::KEY_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rkad_pkg::LEN_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [7:0]                        req_key_index,
   input  logic [7:0]                        req_key_value,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_block_restart,
   input  logic [7:0]                        req_restart_offset,
   input  logic                              req_bypass,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_plain_byte,
   output logic [31:0]                       rsp_block_sum
);

   localparam int AW = $clog2(KEY_DEPTH);
   localparam int BW = rkad_pkg::BYTE_W;
   localparam int LW = rkad_pkg::LEN_W;
   localparam int SW = rkad_pkg::SUM_W;

   logic [LW-1:0] key_length_ff;
   logic [LW-1:0] eff_len;

   logic [BW-1:0] key_position_ff, key_position_in;
   logic [SW-1:0] running_sum_ff, running_sum_in;

   logic          s1_valid_ff;
   logic [BW-1:0] s1_data_ff;
   logic          s1_zero_ff;
   logic          s1_restart_ff;

   logic          out_valid_ff;
   logic [BW-1:0] out_plain_ff;
   logic [SW-1:0] out_sum_ff;

   logic          accept;
   logic          accept_data;
   logic          accept_write;
   logic          s1_advance;

   logic [LW-1:0] pos_start;
   logic [LW-1:0] pos_use;
   logic [LW-1:0] pos_inc;
   logic          pos_in_store;

   logic          wr_en;
   logic          rd_en;
   logic [BW-1:0] key_rd;
   logic [BW-1:0] key_byte;
   logic [BW-1:0] plain;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= rkad_pkg::LEN_MAX;
      end else if (csr_we) begin
         key_length_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (key_length_ff == '0 || key_length_ff > rkad_pkg::LEN_MAX) begin
         eff_len = rkad_pkg::LEN_MAX;
      end else begin
         eff_len = key_length_ff;
      end
   end

   // Handshake.
   assign s1_advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_advance;
   assign accept       = req_valid && req_ready;
   assign accept_data  = accept && (req_opcode == rkad_pkg::OP_DATA);
   assign accept_write = accept && (req_opcode == rkad_pkg::OP_KEY_WRITE);

   // Key position for the accepted data word and its successor.
   always_comb begin
      if (req_block_restart) begin
         pos_start = ({1'b0, req_restart_offset} < eff_len) ?
                     {1'b0, req_restart_offset} : '0;
      end else begin
         pos_start = {1'b0, key_position_ff};
      end
      pos_use = (pos_start >= eff_len) ? '0 : pos_start;
      pos_inc = pos_use + LW'(1);
      if (pos_inc >= eff_len) begin
         pos_inc = '0;
      end
      key_position_in = pos_inc[BW-1:0];
      pos_in_store    = (32'(pos_use) < KEY_DEPTH);
   end

   assign wr_en = accept_write && (32'(req_key_index) < KEY_DEPTH);
   assign rd_en = accept_data;

   rkad_key_store #(
      .KEY_DEPTH (KEY_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_key_index)),
      .wr_data (req_key_value),
      .rd_en   (rd_en),
      .rd_addr (AW'(pos_use)),
      .rd_data (key_rd)
   );

   // Stage one: key byte arrives from the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         key_position_ff <= '0;
      end else begin
         if (accept_data) begin
            s1_valid_ff     <= 1'b1;
            key_position_ff <= key_position_in;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_data) begin
         s1_data_ff    <= req_data_byte;
         s1_zero_ff    <= req_bypass || !pos_in_store;
         s1_restart_ff <= req_block_restart;
      end
   end

   assign key_byte       = s1_zero_ff ? '0 : key_rd;
   assign plain          = s1_data_ff + key_byte;
   assign running_sum_in = (s1_restart_ff ? '0 : running_sum_ff) + SW'(plain);

   // Output register and running sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         running_sum_ff <= '0;
      end else begin
         if (s1_advance) begin
            out_valid_ff   <= 1'b1;
            running_sum_ff <= running_sum_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_plain_ff <= plain;
         out_sum_ff   <= running_sum_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_plain_byte = out_plain_ff;
   assign rsp_block_sum  = out_sum_ff;

   // A stalled word in stage one keeps its place and payload.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("stage one word lost while stalled");

   // Every accepted data word enters stage one.
   assert property (@(posedge clock) disable iff (reset)
      accept_data |=> s1_valid_ff)
      else $error("accepted data word did not enter stage one");

   // A key write on an empty pipeline produces no result.
   assert property (@(posedge clock) disable iff (reset)
      (accept_write && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("key write produced a result");

endmodule

FILE: test/tb_repeating_key_additive_descrambler.sv
// Testbench for the descrambler: directed and random word streams checked against a predictor.
`timescale 1ns / 100ps

module tb_repeating_key_additive_descrambler;

   typedef struct packed {
      rkad_pkg::opcode_type op;
      logic [7:0]  key_index;
      logic [7:0]  key_value;
      logic [7:0]  data_byte;
      logic        block_restart;
      logic [7:0]  restart_offset;
      logic        bypass;
      logic [7:0]  plain_byte;
      logic [31:0] block_sum;
   } stream_word_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [rkad_pkg::LEN_W-1:0] csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_opcode = 1'b0;
   logic [7:0]       req_key_index = '0;
   logic [7:0]       req_key_value = '0;
   logic [7:0]       req_data_byte = '0;
   logic             req_block_restart = 1'b0;
   logic [7:0]       req_restart_offset = '0;
   logic             req_bypass = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_plain_byte;
   logic [31:0]      rsp_block_sum;

   // Predictor state.
   logic [7:0]  key_mem [rkad_pkg::KEY_DEPTH_DEF];
   bit          key_loaded [rkad_pkg::KEY_DEPTH_DEF];
   int          key_pos = 0;
   int          key_len = 256;
   logic [31:0] block_total = '0;

   stream_word_type pending_words [$];
   stream_word_type expected_bytes [$];
   stream_word_type offered;

   int  words_queued = 0;
   int  words_accepted = 0;
   int  key_writes = 0;
   int  bytes_checked = 0;
   int  error_count = 0;
   int  settings_run = 0;
   bit  req_fire = 1'b0;
   int  burst_left = 1;
   int  gap_left = 0;
   int  ready_mode = 0;
   int  mode_left = 0;
   int  hold_left = 0;
   int  next_hold_at = 200;
   int  holds_taken = 0;

   bit [8:0] len_codes [11] = '{9'd1, 9'd2, 9'd5, 9'd16, 9'd255, 9'd256, 9'd0, 9'd511,
                                9'd300, 9'd37, 9'd3};

   repeating_key_additive_descrambler uut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_key_index      (req_key_index),
      .req_key_value      (req_key_value),
      .req_data_byte      (req_data_byte),
      .req_block_restart  (req_block_restart),
      .req_restart_offset (req_restart_offset),
      .req_bypass         (req_bypass),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_plain_byte     (rsp_plain_byte),
      .rsp_block_sum      (rsp_block_sum)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int effective_length(bit [8:0] code);
      return (code == 9'd0 || code > 9'd256) ? 256 : int'(code);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_bit();
      return ($urandom_range(0, 1) == 1);
   endfunction

   // Key position that the next data word reads.
   function automatic int read_slot(logic restart, logic [7:0] offset);
      int slot;
      slot = restart ? ((int'(offset) < key_len) ? int'(offset) : 0) : key_pos;
      if (slot >= key_len) slot = 0;
      return slot;
   endfunction

   function automatic stream_word_type descramble_predict(stream_word_type w);
      int         slot;
      logic [7:0] key_byte;
      if (w.op == rkad_pkg::OP_KEY_WRITE) begin
         key_mem[w.key_index] = w.key_value;
         key_loaded[w.key_index] = 1'b1;
         return w;
      end
      slot = read_slot(w.block_restart, w.restart_offset);
      if (w.block_restart) block_total = '0;
      key_byte = w.bypass ? 8'h00 : key_mem[slot];
      key_pos = (slot + 1 >= key_len) ? 0 : slot + 1;
      w.plain_byte = w.data_byte + key_byte;
      block_total = block_total + 32'(w.plain_byte);
      w.block_sum = block_total;
      return w;
   endfunction

   function automatic stream_word_type random_word();
      stream_word_type w;
      w.op = rkad_pkg::OP_DATA;
      w.key_index = rand_byte();
      w.key_value = rand_byte();
      w.data_byte = rand_byte();
      w.block_restart = rand_bit();
      w.restart_offset = rand_byte();
      w.bypass = rand_bit();
      w.plain_byte = '0;
      w.block_sum = '0;
      return w;
   endfunction

   task automatic queue_word(stream_word_type w);
      pending_words.push_back(descramble_predict(w));
      words_queued++;
      if (w.op == rkad_pkg::OP_KEY_WRITE) key_writes++;
   endtask

   task automatic queue_key(logic [7:0] index, logic [7:0] value);
      stream_word_type w;
      w = random_word();
      w.op = rkad_pkg::OP_KEY_WRITE;
      w.key_index = index;
      w.key_value = value;
      queue_word(w);
   endtask

   // A key entry that a non-bypassed data word is about to read is loaded first if it never was.
   task automatic queue_data(logic [7:0] data, logic restart, logic [7:0] offset,
                             logic bypass);
      stream_word_type w;
      int           slot;
      slot = read_slot(restart, offset);
      if (!bypass && !key_loaded[slot]) queue_key(8'(slot), rand_byte());
      w = random_word();
      w.data_byte = data;
      w.block_restart = restart;
      w.restart_offset = offset;
      w.bypass = bypass;
      queue_word(w);
   endtask

   task automatic wait_idle();
      while (words_accepted != words_queued || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_setting(bit [8:0] code, int word_count);
      int         first;
      int         run;
      int         base;
      logic [7:0] offset;
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= code;
      @(negedge clock);
      csr_we <= 1'b0;
      key_len = effective_length(code);
      settings_run++;
      first = words_queued;
      if (key_len <= 64) begin
         base = $urandom_range(0, key_len - 1);
         for (int i = 0; i < key_len; i++)
            queue_key(8'((base + i) % key_len), rand_byte());
      end
      // Offsets at and past the key length restart at position zero.
      queue_data(rand_byte(), 1'b1, 8'(key_len % 256), 1'b0);
      queue_data(rand_byte(), 1'b1, 8'hFF, 1'b0);
      while (words_queued - first < word_count) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_key(rand_byte(), rand_byte());
            end
            1: begin
               queue_data(rand_byte(), rand_bit(), rand_byte(), rand_bit());
            end
            default: begin
               run = $urandom_range(1, 20);
               offset = ($urandom_range(0, 7) == 0) ? rand_byte()
                                                    : 8'($urandom_range(0, key_len - 1));
               queue_data(rand_byte(), 1'b1, offset, $urandom_range(0, 7) == 0);
               for (int i = 1; i < run; i++)
                  queue_data(rand_byte(), 1'b0, rand_byte(), $urandom_range(0, 7) == 0);
            end
         endcase
      end
   endtask

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Sender: bursts of words separated by random gaps.
   always @(negedge clock) begin
      stream_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            offered <= w;
            req_valid <= 1'b1;
            req_opcode <= w.op;
            req_key_index <= w.key_index;
            req_key_value <= w.key_value;
            req_data_byte <= w.data_byte;
            req_block_restart <= w.block_restart;
            req_restart_offset <= w.restart_offset;
            req_bypass <= w.bypass;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-offs, started as the accepted word count passes marks.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (words_accepted >= next_hold_at) begin
         hold_left <= $urandom_range(120, 250);
         next_hold_at <= next_hold_at + 600;
         holds_taken <= holds_taken + 1;
      end
   end

   // Receiver: stall pattern that switches between modes.
   always @(negedge clock) begin
      logic ready_next;
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(16, 64);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         0: ready_next = 1'b1;
         1: ready_next = rand_bit();
         2: ready_next = ($urandom_range(0, 3) == 0);
         default: ready_next = mode_left[1];
      endcase
      rsp_ready <= ready_next && (hold_left == 0);
   end

   // Monitor and checker.
   always @(posedge clock) begin
      stream_word_type want;
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            bytes_checked <= bytes_checked + 1;
            if (expected_bytes.size() == 0) begin
               flag_error($sformatf("result with nothing expected: plain %02h sum %08h",
                                    rsp_plain_byte, rsp_block_sum));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_plain_byte !== want.plain_byte)
                  flag_error($sformatf("plain_byte expected %02h actual %02h",
                                       want.plain_byte, rsp_plain_byte));
               if (rsp_block_sum !== want.block_sum)
                  flag_error($sformatf("block_sum expected %08h actual %08h",
                                       want.block_sum, rsp_block_sum));
            end
         end
         if (req_valid && req_ready) begin
            words_accepted <= words_accepted + 1;
            if (offered.op == rkad_pkg::OP_DATA) expected_bytes.push_back(offered);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      stream_word_type special;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset key length.
      queue_key(8'hFF, 8'hFF);
      queue_key(8'h00, 8'h01);
      queue_key(8'h80, 8'h80);
      queue_data(8'hFF, 1'b1, 8'hFF, 1'b0);
      queue_data(8'h00, 1'b0, 8'h00, 1'b0);
      queue_data(8'h7F, 1'b1, 8'h80, 1'b1);
      queue_data(8'h80, 1'b0, 8'hFF, 1'b0);
      queue_data(8'hFF, 1'b1, 8'h00, 1'b0);
      queue_data(8'hFF, 1'b0, 8'h00, 1'b1);
      // A key write with every other field set must not disturb position or sum.
      special = random_word();
      special.op = rkad_pkg::OP_KEY_WRITE;
      special.key_index = 8'h02;
      special.key_value = 8'hFF;
      special.data_byte = 8'hFF;
      special.block_restart = 1'b1;
      special.restart_offset = 8'hFF;
      special.bypass = 1'b1;
      queue_word(special);
      queue_data(8'h01, 1'b0, 8'h00, 1'b0);
      queue_data(8'h00, 1'b0, 8'h00, 1'b0);
      queue_data(8'hFF, 1'b1, 8'h80, 1'b0);
      queue_data(8'h00, 1'b1, 8'h00, 1'b1);

      foreach (len_codes[i]) run_setting(len_codes[i], 125);
      run_setting(9'($urandom_range(0, 511)), 60);

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_bytes.size() != 0)
         flag_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      $display("Checked %0d descrambled bytes from %0d words (%0d key writes)",
               bytes_checked, words_accepted, key_writes);
      $display("over %0d key lengths; the receiver held off %0d times under load.",
               settings_run + 1, holds_taken);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
